FILE: hw/rtl/pidff_pkg.sv
package pidff_pkg;

   localparam int DATA_W = 32;
   localparam int OPND_W = 33;
   localparam int PROD_W = 66;
   localparam int ACC_W  = 68;
   localparam int LIM_W  = 31;
   localparam int ADDR_W = 3;

   typedef enum logic [ADDR_W-1:0] {
      REG_GAIN_PROP      = 3'd0,
      REG_GAIN_INTEGRAL  = 3'd1,
      REG_GAIN_DERIV     = 3'd2,
      REG_GAIN_FEEDFWD   = 3'd3,
      REG_INTEGRAL_CLAMP = 3'd4,
      REG_DRIVE_CLAMP    = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      MUL_NONE = 3'd0,
      MUL_P    = 3'd1,
      MUL_KDT  = 3'd2,
      MUL_INC  = 3'd3,
      MUL_D    = 3'd4,
      MUL_F    = 3'd5
   } mul_op_type;

   typedef enum logic [2:0] {
      POST_NONE   = 3'd0,
      POST_SETACC = 3'd1,
      POST_KDT    = 3'd2,
      POST_INTEG  = 3'd3,
      POST_ADDACC = 3'd4
   } post_op_type;

   typedef struct packed {
      logic        load;
      mul_op_type  mul_op;
      post_op_type post_op;
      logic        div_start;
      logic        out_write;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_busy;
   } status_type;

   // Clamp to +/- lim when lim is nonzero, else saturate to the signed 32-bit range.
   function automatic logic signed [DATA_W-1:0] limit_sat(input logic signed [ACC_W-1:0] x,
                                                         input logic [LIM_W-1:0] lim);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      if (lim != '0) begin
         hi = $signed({{(ACC_W-LIM_W){1'b0}}, lim});
         lo = -hi;
      end else begin
         hi = $signed({{(ACC_W-LIM_W){1'b0}}, {LIM_W{1'b1}}});
         lo = ~hi;
      end
      if (x > hi) begin
         limit_sat = hi[DATA_W-1:0];
      end else if (x < lo) begin
         limit_sat = lo[DATA_W-1:0];
      end else begin
         limit_sat = x[DATA_W-1:0];
      end
   endfunction

endpackage

FILE: hw/rtl/pidff_div.sv
module pidff_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [pidff_pkg::OPND_W-1:0] diff,
   input  logic [pidff_pkg::DATA_W-1:0]        divisor,
   output logic                                done,
   output logic signed [pidff_pkg::DATA_W-1:0] quot
);
   import pidff_pkg::*;

   localparam int NUM_W = OPND_W + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0]  q_ff, q_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic [OPND_W-1:0] mag;
   logic [DATA_W:0]   trial;
   logic              ge;
   logic              over_pos, over_neg;

   assign mag   = diff[OPND_W-1] ? OPND_W'(-diff) : OPND_W'(diff);
   assign trial = {rem_ff, q_ff[NUM_W-1]};
   assign ge    = trial >= {1'b0, divisor};

   always_comb begin
      rem_in = rem_ff;
      q_in   = q_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      if (start) begin
         rem_in = '0;
         q_in   = {mag, {FRAC_BITS{1'b0}}};
         cnt_in = CNT_W'(NUM_W);
         neg_in = diff[OPND_W-1];
      end else if (cnt_ff != '0) begin
         rem_in = ge ? DATA_W'(trial - {1'b0, divisor}) : trial[DATA_W-1:0];
         q_in   = {q_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign done     = (cnt_ff == '0);
   assign over_pos = |q_ff[NUM_W-1:DATA_W-1];
   assign over_neg = (|q_ff[NUM_W-1:DATA_W]) || (q_ff[DATA_W-1] && (|q_ff[DATA_W-2:0]));

   always_comb begin
      if (neg_ff) begin
         quot = over_neg ? {1'b1, {(DATA_W-1){1'b0}}} : -$signed(q_ff[DATA_W-1:0]);
      end else begin
         quot = over_pos ? {1'b0, {(DATA_W-1){1'b1}}} : $signed(q_ff[DATA_W-1:0]);
      end
   end

endmodule

FILE: hw/rtl/pidff_datapath.sv
module pidff_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pidff_pkg::cmd_type                  cmd,
   output pidff_pkg::status_type               status,
   input  logic                                csr_we,
   input  logic [pidff_pkg::ADDR_W-1:0]        csr_addr,
   input  logic [pidff_pkg::DATA_W-1:0]        csr_wdata,
   input  logic [3*pidff_pkg::DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pidff_pkg::DATA_W-1:0]        rsp_tdata,
   output logic                                rsp_tuser
);
   import pidff_pkg::*;

   logic signed [DATA_W-1:0] kp_ff, ki_ff, kd_ff, kf_ff;
   logic [LIM_W-1:0]         ilim_ff, ulim_ff;
   logic signed [DATA_W-1:0] integ_ff, eprev_ff;
   logic signed [DATA_W-1:0] e_ff, feed_ff, kdt_ff;
   logic [DATA_W-1:0]        dt_ff;
   logic signed [OPND_W-1:0] sum_ff, diff_ff;
   logic                     zero_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     rsp_valid_ff;
   logic [DATA_W-1:0]        rsp_data_ff;
   logic                     rsp_flag_ff;

   logic signed [OPND_W-1:0] opa, opb;
   logic signed [PROD_W-1:0] sh_f, sh_f1;
   logic signed [ACC_W-1:0]  isum;
   logic signed [DATA_W-1:0] i_new, de, div_q, kdt_in;
   logic signed [DATA_W-1:0] req_err, req_feed;
   logic [DATA_W-1:0]        req_dt;
   logic                     div_done;

   localparam logic signed [PROD_W-1:0] KDT_MAX = PROD_W'({1'b0, {(DATA_W-1){1'b1}}});

   assign req_err  = req_tdata[DATA_W-1:0];
   assign req_feed = req_tdata[2*DATA_W-1:DATA_W];
   assign req_dt   = req_tdata[3*DATA_W-1:2*DATA_W];

   pidff_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .diff    (diff_ff),
      .divisor (dt_ff),
      .done    (div_done),
      .quot    (div_q)
   );

   assign de = zero_ff ? '0 : div_q;

   always_comb begin
      case (cmd.mul_op)
         MUL_P: begin
            opa = OPND_W'(kp_ff);
            opb = OPND_W'(e_ff);
         end
         MUL_KDT: begin
            opa = OPND_W'(ki_ff);
            opb = $signed({1'b0, dt_ff});
         end
         MUL_INC: begin
            opa = OPND_W'(kdt_ff);
            opb = sum_ff;
         end
         MUL_D: begin
            opa = OPND_W'(kd_ff);
            opb = OPND_W'(de);
         end
         MUL_F: begin
            opa = OPND_W'(kf_ff);
            opb = OPND_W'(feed_ff);
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   assign sh_f  = prod_ff >>> FRAC_BITS;
   assign sh_f1 = prod_ff >>> (FRAC_BITS + 1);
   assign isum  = ACC_W'(integ_ff) + ACC_W'(sh_f1);
   assign i_new = limit_sat(isum, ilim_ff);
   assign kdt_in = (sh_f > KDT_MAX) ? KDT_MAX[DATA_W-1:0] :
                   (sh_f < -KDT_MAX) ? DATA_W'(-KDT_MAX) : sh_f[DATA_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         e_ff    <= req_err;
         feed_ff <= req_feed;
         dt_ff   <= req_dt;
         sum_ff  <= OPND_W'(req_err) + OPND_W'(eprev_ff);
         diff_ff <= OPND_W'(req_err) - OPND_W'(eprev_ff);
         zero_ff <= (req_dt == '0);
      end
      if (cmd.mul_op != MUL_NONE) begin
         prod_ff <= opa * opb;
      end
      case (cmd.post_op)
         POST_SETACC: acc_ff <= ACC_W'(sh_f);
         POST_KDT:    kdt_ff <= kdt_in;
         POST_INTEG:  acc_ff <= acc_ff + ACC_W'(i_new);
         POST_ADDACC: acc_ff <= acc_ff + ACC_W'(sh_f);
         default:     ;
      endcase
      if (cmd.out_write) begin
         rsp_data_ff <= limit_sat(acc_ff, ulim_ff);
         rsp_flag_ff <= zero_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= '0;
         ki_ff        <= '0;
         kd_ff        <= '0;
         kf_ff        <= '0;
         ilim_ff      <= '0;
         ulim_ff      <= '0;
         integ_ff     <= '0;
         eprev_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_GAIN_PROP:      kp_ff   <= csr_wdata;
               REG_GAIN_INTEGRAL:  ki_ff   <= csr_wdata;
               REG_GAIN_DERIV:     kd_ff   <= csr_wdata;
               REG_GAIN_FEEDFWD:   kf_ff   <= csr_wdata;
               REG_INTEGRAL_CLAMP: ilim_ff <= csr_wdata[LIM_W-1:0];
               REG_DRIVE_CLAMP:    ulim_ff <= csr_wdata[LIM_W-1:0];
               default:            ;
            endcase
         end
         if (cmd.post_op == POST_INTEG) begin
            integ_ff <= i_new;
         end
         if (cmd.out_write) begin
            eprev_ff     <= e_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.div_done = div_done;
   assign status.out_busy = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign rsp_tuser       = rsp_flag_ff;

endmodule

FILE: hw/rtl/pidff_ctrl.sv
module pidff_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  pidff_pkg::status_type status,
   output pidff_pkg::cmd_type    cmd
);
   import pidff_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_MP   = 11'b000_0000_0010,
      S_MK   = 11'b000_0000_0100,
      S_KS   = 11'b000_0000_1000,
      S_MI   = 11'b000_0001_0000,
      S_IN   = 11'b000_0010_0000,
      S_DV   = 11'b000_0100_0000,
      S_MD   = 11'b000_1000_0000,
      S_MF   = 11'b001_0000_0000,
      S_AF   = 11'b010_0000_0000,
      S_OUT  = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '{load: 1'b0, mul_op: MUL_NONE, post_op: POST_NONE,
                    div_start: 1'b0, out_write: 1'b0};
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_MP;
            end
         end
         S_MP: begin
            cmd.mul_op = MUL_P;
            state_in   = S_MK;
         end
         S_MK: begin
            cmd.mul_op  = MUL_KDT;
            cmd.post_op = POST_SETACC;
            state_in    = S_KS;
         end
         S_KS: begin
            cmd.post_op   = POST_KDT;
            cmd.div_start = 1'b1;
            state_in      = S_MI;
         end
         S_MI: begin
            cmd.mul_op = MUL_INC;
            state_in   = S_IN;
         end
         S_IN: begin
            cmd.post_op = POST_INTEG;
            state_in    = S_DV;
         end
         S_DV: begin
            if (status.div_done) begin
               state_in = S_MD;
            end
         end
         S_MD: begin
            cmd.mul_op = MUL_D;
            state_in   = S_MF;
         end
         S_MF: begin
            cmd.mul_op  = MUL_F;
            cmd.post_op = POST_ADDACC;
            state_in    = S_AF;
         end
         S_AF: begin
            cmd.post_op = POST_ADDACC;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (!status.out_busy) begin
               cmd.out_write = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

FILE: hw/rtl/pid_trapezoid_feedforward_unit.sv
// The derivative term uses a restoring divider, which retires one quotient bit per cycle
// over FRAC_BITS+33 bits (49 at the default Q16.16 format).
// A response that is still waiting when the next one is ready holds the block until it is taken.
// A shared 33x33 multiplier serves the five products in turn.
// Reset is synchronous and active high; it clears the gains, limits, integral and previous
// error to zero and empties the response register.
module pid_trapezoid_feedforward_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // err_sample [31:0], feed_value [63:32], step_time [95:64]
   input  logic [3*pidff_pkg::DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // drive [31:0]
   output logic [pidff_pkg::DATA_W-1:0]       rsp_tdata,
   // zero_step_flag [0]
   output logic                               rsp_tuser,
   input  logic                               csr_we,
   input  logic [pidff_pkg::ADDR_W-1:0]       csr_addr,
   input  logic [pidff_pkg::DATA_W-1:0]       csr_wdata
);
   import pidff_pkg::*;

   // The controller steps through the terms of the control law while the datapath holds
   // the gains, the loop state and one product register. The response sits in its own
   // register, so a new request is taken while the previous response still waits.
   cmd_type    cmd;
   status_type status;

   pidff_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pidff_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Once a transaction is taken, the block stays busy until its response is written.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a transaction is in progress");

   // A response is never written over one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_write |-> (!rsp_tvalid || rsp_tready))
      else $error("response register overwritten");

   // The derivative product only uses a finished quotient.
   a_div_ready: assert property (@(posedge clock) disable iff (reset)
      (cmd.mul_op == MUL_D) |-> status.div_done)
      else $error("derivative product taken before division finished");

endmodule
